@@ design/sist_pkg.sv @@
// ----------------------------------------------------------------------------
// sist_pkg: shared types for the sorted integer set table
// Request and status codes, controller states, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sist_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned MemberW = 31;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned StatusW = 3;

  typedef enum logic [ReqW-1:0] {
    REQ_ADD   = 2'd0,
    REQ_ERASE = 2'd1,
    REQ_TEST  = 2'd2,
    REQ_LIST  = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_ADD_ERR   = 3'd1,
    ST_ERASE_ERR = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_LIST = 2'd2
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;      // latch the incoming request
    logic exec_single;  // run a single-result request and load its word
    logic list_start;   // reset the listing counter
    logic list_step;    // emit the lowest cell and rotate
  } sist_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic list_req;     // captured request is a listing
    logic empty;        // no members held
    logic list_last;    // current listing word is the final one
  } sist_stat_t;

endpackage

@@ design/sist_req_if.sv @@
// ----------------------------------------------------------------------------
// sist_req_if: request channel
// Valid/ready channel carrying one request word: type and signed value.
// ----------------------------------------------------------------------------
interface sist_req_if
  import sist_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [ReqW-1:0]          req_type;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

@@ design/sist_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sist_rsp_if: response channel
// Valid/ready channel carrying one result word: status, found, member, last.
// ----------------------------------------------------------------------------
interface sist_rsp_if
  import sist_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic               found;
  logic [MemberW-1:0] member;
  logic               last;

  modport source (output valid, output status, output found, output member,
                  output last, input ready);
  modport sink   (input valid, input status, input found, input member,
                  input last, output ready);
endinterface

@@ design/sorted_integer_set_table.sv @@
// ----------------------------------------------------------------------------
// sorted_integer_set_table: set of distinct non-negative integers
// Add, erase, membership test and ascending listing over up to CAPACITY
// members held in compare-in-place cells.
// ----------------------------------------------------------------------------
// The table holds up to CAPACITY distinct non-negative 31-bit values, kept
// ascending in a row of cells that each compare against the request value in
// the same cycle. An add, erase or membership test gives one result word: the
// accepting edge latches the request, and a later edge, once the result
// register is free, does the parallel compare, the cell update and loads the
// word. A listing gives one word per member, lowest first, with last set on
// the highest, at one word a cycle while the sink takes them, after a start
// that latches the request and then resets the listing counter; an empty set
// lists as one word with status empty. Listing works by rotating the
// occupied cells, so the set is back in order after its final word. One
// request is in hand at a time: the next is taken once the current request's
// last word sits in the result register, which may still be waiting for the
// sink. Status codes: 0 ok, 1 add of a negative value, 2 erase of a negative
// or absent value, 3 add while full, 4 empty listing. found reports whether
// the value was a member before the request; member is zero outside listings.
// Adding a present value is ok with found set and changes nothing, even when
// full. Cells need no reset clearing: only the member and listing counts reset.
module sorted_integer_set_table
  import sist_pkg::*;
#(
  parameter int unsigned CAPACITY = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sist_req_if.sink   req_i,
  sist_rsp_if.source rsp_o
);

  sist_cmd_t  cmd;
  sist_stat_t stat;

  sist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sist_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_type_i (req_i.req_type),
    .value_i    (req_i.value),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .status_o   (rsp_o.status),
    .found_o    (rsp_o.found),
    .member_o   (rsp_o.member),
    .last_o     (rsp_o.last)
  );

endmodule

@@ design/sist_datapath.sv @@
// ----------------------------------------------------------------------------
// sist_datapath: member cells, request latch and result register
// Each cell compares against the latched value in parallel; insert and
// erase move data between neighbouring cells only; listing wraps cell 0 to top.
// ----------------------------------------------------------------------------
module sist_datapath
  import sist_pkg::*;
#(
  parameter int unsigned CAPACITY = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [ReqW-1:0]          req_type_i,
  input  logic signed [ValueW-1:0] value_i,
  input  sist_cmd_t                cmd_i,
  output sist_stat_t               stat_o,
  output logic [StatusW-1:0]       status_o,
  output logic                     found_o,
  output logic [MemberW-1:0]       member_o,
  output logic                     last_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  // latched request
  req_e               req_q;
  logic               neg_q;
  logic [MemberW-1:0] val_q;

  // member cells, ascending in 0 .. count-1
  logic [MemberW-1:0] mem_q [CAPACITY];
  logic [MemberW-1:0] mem_d [CAPACITY];
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    list_idx_q, list_idx_d;

  // result register
  logic [StatusW-1:0] status_q, status_d;
  logic               found_q, found_d;
  logic [MemberW-1:0] member_q, member_d;
  logic               last_q, last_d;

  logic [CAPACITY-1:0] cell_vld, hit, gt, ge;
  logic                hit_any, list_last;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_vld[i] = CntW'(i) < count_q;
      hit[i]      = cell_vld[i] && !neg_q && (mem_q[i] == val_q);
      gt[i]       = cell_vld[i] && (mem_q[i] > val_q);
      ge[i]       = cell_vld[i] && (mem_q[i] >= val_q);
    end
  end

  assign hit_any   = |hit;
  assign list_last = (list_idx_q == count_q - CntW'(1));

  always_comb begin
    mem_d      = mem_q;
    count_d    = count_q;
    list_idx_d = list_idx_q;
    status_d   = status_q;
    found_d    = found_q;
    member_d   = member_q;
    last_d     = last_q;

    if (cmd_i.list_start) begin
      list_idx_d = '0;
    end

    if (cmd_i.exec_single) begin
      status_d = ST_OK;
      found_d  = 1'b0;
      member_d = '0;
      last_d   = 1'b1;
      case (req_q)
        REQ_ADD: begin
          if (neg_q) begin
            status_d = ST_ADD_ERR;
          end else if (hit_any) begin
            found_d = 1'b1;
          end else if (count_q == CapCnt) begin
            status_d = ST_FULL;
          end else begin
            // cells above the insert point move up by one
            for (int i = 0; i < CAPACITY; i++) begin
              if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                mem_d[i] = mem_q[(i > 0) ? i - 1 : 0];
              end else if (gt[i] || CntW'(i) == count_q) begin
                mem_d[i] = val_q;
              end
            end
            count_d = count_q + CntW'(1);
          end
        end
        REQ_ERASE: begin
          if (hit_any) begin
            found_d = 1'b1;
            // the hit cell and all above it take their upper neighbour
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (ge[i]) begin
                mem_d[i] = mem_q[i + 1];
              end
            end
            count_d = count_q - CntW'(1);
          end else begin
            status_d = ST_ERASE_ERR;
          end
        end
        REQ_TEST: begin
          found_d = hit_any;
        end
        REQ_LIST: begin
          status_d = ST_EMPTY;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end

    if (cmd_i.list_step) begin
      status_d = ST_OK;
      found_d  = 1'b0;
      member_d = mem_q[0];
      last_d   = list_last;
      // rotate the occupied cells down; cell 0 wraps to the top
      for (int i = 0; i < CAPACITY; i++) begin
        if (CntW'(i + 1) < count_q) begin
          mem_d[i] = mem_q[(i < CAPACITY - 1) ? i + 1 : i];
        end else if (CntW'(i + 1) == count_q) begin
          mem_d[i] = mem_q[0];
        end
      end
      list_idx_d = list_idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      list_idx_q <= '0;
    end else begin
      count_q    <= count_d;
      list_idx_q <= list_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mem_q    <= mem_d;
    status_q <= status_d;
    found_q  <= found_d;
    member_q <= member_d;
    last_q   <= last_d;
    if (cmd_i.capture) begin
      req_q <= req_e'(req_type_i);
      neg_q <= value_i[ValueW-1];
      val_q <= value_i[MemberW-1:0];
    end
  end

  assign stat_o.list_req  = (req_q == REQ_LIST);
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.list_last = list_last;

  assign status_o = status_q;
  assign found_o  = found_q;
  assign member_o = member_q;
  assign last_o   = last_q;

endmodule

@@ design/sist_ctrl.sv @@
// ----------------------------------------------------------------------------
// sist_ctrl: request sequencer
// Takes a request, runs it in the datapath and paces result words against
// the output handshake.
// ----------------------------------------------------------------------------
module sist_ctrl
  import sist_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  sist_stat_t stat_i,
  output sist_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  // result register is free or being emptied this cycle
  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.list_req && !stat_i.empty) begin
          cmd_o.list_start = 1'b1;
          state_d          = S_LIST;
        end else if (can_load) begin
          cmd_o.exec_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_LIST: begin
        if (can_load) begin
          cmd_o.list_step = 1'b1;
          if (stat_i.list_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cmd_o.exec_single || cmd_o.list_step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
